/* design/polyphase_fractional_resampler_assert.svh */
// Assertion macros for the resampler.
`ifndef POLYPHASE_FRACTIONAL_RESAMPLER_ASSERT_SVH
`define POLYPHASE_FRACTIONAL_RESAMPLER_ASSERT_SVH

// Antecedent implies consequent on the next edge.
`define PFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Condition holds on every edge out of reset.
`define PFR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

`endif

/* design/pfr_pkg.sv */
package pfr_pkg;

   localparam int TAPS_DEF      = 8;
   localparam int PHASES_DEF    = 16;
   localparam int COEF_BITS_DEF = 14;
   localparam int MAX_LEN_DEF   = 2048;

   localparam int FRAC_BITS = 11;
   localparam int ACC_W     = 13;
   localparam int POS_W     = 12;
   localparam int SAMP_W    = 16;
   localparam int OUT_W     = 20;
   localparam int IDX_W     = 11;

   localparam logic [1:0] REQ_LOAD_COEF   = 2'd0;
   localparam logic [1:0] REQ_LOAD_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_START       = 2'd2;
   localparam logic [1:0] REQ_PRODUCE     = 2'd3;

   localparam logic CSR_BLOCK_LENGTH = 1'b0;
   localparam logic CSR_LOG2_OUT_LEN = 1'b1;

   // Round-half-away-from-zero right shift of a 64-bit value.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input int n);
      logic [63:0] mag;
      logic [63:0] half;
      half = 64'd1 << (n - 1);
      mag  = x[63] ? 64'(-x) : 64'(x);
      mag  = (mag + half) >> n;
      return x[63] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat20(input logic signed [47:0] x);
      if (x > 48'sd524287) return 20'sh7FFFF;
      if (x < -48'sd524288) return 20'sh80000;
      return x[OUT_W-1:0];
   endfunction

endpackage

/* design/polyphase_fractional_resampler.sv */
// Channel   Dir  tdata fields (low bit first)                tuser
// req_      in   index[10:0] coef_value[24:11]               req_type
//                in_re[40:25] in_im[56:41], pad to 64
// rsp_      out  out_re[19:0] out_im[39:20] out_index[50:40]  -, tlast = last
// csr_      in   index selects register, data is value
// Loads pass through a load step; start does one store read per tap. Produce shifts
// samples in, then per tap reads, interpolates and multiplies, with a correction on
// the last phase; one shared multiplier does interpolation and tap products.
// Reset is synchronous and clears control state; stores are undefined until written.
// req_tready drops while an item is worked on; a waiting result holds a produce
// in its output step until the result word is taken.
`include "polyphase_fractional_resampler_assert.svh"
module polyphase_fractional_resampler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // index, coef_value, in_re, in_im
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_re, out_im, out_index
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   localparam int TAPS      = pfr_pkg::TAPS_DEF;
   localparam int PHASES    = pfr_pkg::PHASES_DEF;
   localparam int COEF_BITS = pfr_pkg::COEF_BITS_DEF;
   localparam int MAX_LEN   = pfr_pkg::MAX_LEN_DEF;
   localparam int NCOEF = TAPS * PHASES;
   localparam int CA_W  = $clog2(NCOEF);
   localparam int SA_W  = $clog2(MAX_LEN);
   localparam int TI_W  = $clog2(TAPS + 2);
   localparam int PI_W  = $clog2(PHASES);
   localparam int PH_SH = $clog2(PHASES);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_LOAD  = 10'b0000000010,
      ST_FILL  = 10'b0000000100,
      ST_SHIFT = 10'b0000001000,
      ST_CRD   = 10'b0000010000,
      ST_CINT  = 10'b0000100000,
      ST_MRE   = 10'b0001000000,
      ST_MIM   = 10'b0010000000,
      ST_CORR  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [COEF_BITS-1:0] coef_mem [NCOEF];
   logic signed [15:0] samp_re_mem [MAX_LEN];
   logic signed [15:0] samp_im_mem [MAX_LEN];
   logic signed [15:0] tap_re_ff [TAPS+1];
   logic signed [15:0] tap_im_ff [TAPS+1];

   logic [11:0] blen_ff;
   logic [3:0]  log2_ff;
   logic [12:0] acc_ff;
   logic [11:0] rpos_ff;
   logic [11:0] cnt_ff;
   logic [TI_W-1:0] tap_ff;
   logic        first_ff;
   logic [1:0]  rtype_ff;
   logic [pfr_pkg::IDX_W-1:0] ridx_ff;
   logic signed [13:0] rcoef_ff;
   logic signed [15:0] rre_ff, rim_ff;
   logic signed [COEF_BITS-1:0] c1_ff, c2_ff;
   logic signed [COEF_BITS+1:0] cint_ff;
   logic signed [47:0] are_ff, aim_ff;
   logic signed [15:0] srd_re_ff, srd_im_ff;
   logic        rvalid_ff;
   logic [55:0] rdata_ff;
   logic        rlast_ff;

   // derived phase
   logic [3:0]  ldn;
   logic [11:0] len;
   logic [PI_W+11:0] amp;
   logic [PI_W-1:0] pint;
   logic [10:0] pdec;
   logic [11:0] ppos;
   logic [CA_W-1:0] a1, a2;
   logic signed [47:0] prod;
   logic signed [31:0] mul_a, mul_b;
   logic        out_go;

   assign ldn  = (log2_ff > 4'd11) ? 4'd11 : log2_ff;
   assign len  = 12'd1 << ldn;
   assign amp  = (PI_W+12)'(acc_ff) << PH_SH;
   assign pint = amp[PI_W+10:11];
   assign pdec = amp[10:0];
   assign ppos = (rpos_ff >= blen_ff) ? rpos_ff - blen_ff : rpos_ff;
   assign a1   = CA_W'(tap_ff) * CA_W'(PHASES) + CA_W'(pint);
   assign a2   = a1 + CA_W'(1);

   // output register free or being emptied this cycle
   assign out_go = (state_ff == ST_OUT) && (!rvalid_ff || rsp_tready);

   // the one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CINT: begin
            mul_a = 32'(c2_ff) - 32'(c1_ff);
            mul_b = {21'd0, pdec};
         end
         ST_MRE: begin
            mul_a = 32'(tap_re_ff[tap_ff + TI_W'(1)]);
            mul_b = 32'(cint_ff);
         end
         ST_MIM: begin
            mul_a = 32'(tap_im_ff[tap_ff + TI_W'(1)]);
            mul_b = 32'(cint_ff);
         end
         ST_CORR: begin
            mul_a = first_ff ? 32'(tap_re_ff[TAPS]) - 32'(tap_re_ff[0])
                             : 32'(tap_im_ff[TAPS]) - 32'(tap_im_ff[0]);
            mul_b = {21'd0, pdec};
         end
         default: ;
      endcase
      prod = 48'(mul_a) * 48'(mul_b);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

   always_ff @(posedge clock) begin
      if (csr_valid) begin
         case (csr_index)
            pfr_pkg::CSR_BLOCK_LENGTH: blen_ff <= csr_data;
            pfr_pkg::CSR_LOG2_OUT_LEN: log2_ff <= csr_data[3:0];
            default: ;
         endcase
      end
      if (reset) begin
         blen_ff <= 12'd12;
         log2_ff <= 4'd4;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         if (rtype_ff == pfr_pkg::REQ_LOAD_COEF && 32'(ridx_ff) < NCOEF)
            coef_mem[CA_W'(ridx_ff)] <= rcoef_ff[COEF_BITS-1:0];
         if (rtype_ff == pfr_pkg::REQ_LOAD_SAMPLE && 32'(ridx_ff) < MAX_LEN) begin
            samp_re_mem[SA_W'(ridx_ff)] <= rre_ff;
            samp_im_mem[SA_W'(ridx_ff)] <= rim_ff;
         end
      end
      c1_ff <= coef_mem[a1];
      c2_ff <= coef_mem[a2];
      srd_re_ff <= samp_re_mem[(state_ff == ST_FILL) ? SA_W'(tap_ff) : SA_W'(ppos)];
      srd_im_ff <= samp_im_mem[(state_ff == ST_FILL) ? SA_W'(tap_ff) : SA_W'(ppos)];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_tvalid && req_tready) begin
               case (req_tuser)
                  pfr_pkg::REQ_START: state_in = ST_FILL;
                  pfr_pkg::REQ_PRODUCE:
                     state_in = (cnt_ff >= len) ? ST_IDLE : ST_SHIFT;
                  default: state_in = ST_LOAD;
               endcase
            end
         ST_LOAD: state_in = ST_IDLE;
         ST_FILL:
            if (!first_ff && tap_ff == TI_W'(TAPS + 1)) state_in = ST_IDLE;
         ST_SHIFT:
            if (acc_ff < 13'd2048 && first_ff) state_in = ST_CRD;
         ST_CRD:  state_in = ST_CINT;
         ST_CINT: state_in = ST_MRE;
         ST_MRE:  state_in = ST_MIM;
         ST_MIM:
            if (tap_ff == TI_W'(TAPS - 1))
               state_in = (32'(pint) >= PHASES - 1) ? ST_CORR : ST_OUT;
            else state_in = ST_CRD;
         ST_CORR: if (!first_ff) state_in = ST_OUT;
         ST_OUT:  if (out_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (out_go) rvalid_ff <= 1'b1;
      else if (rsp_tready) rvalid_ff <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rtype_ff <= req_tuser;
            ridx_ff  <= req_tdata[10:0];
            rcoef_ff <= req_tdata[24:11];
            rre_ff   <= req_tdata[40:25];
            rim_ff   <= req_tdata[56:41];
            tap_ff   <= '0;
            first_ff <= 1'b1;
            are_ff   <= '0;
            aim_ff   <= '0;
         end
         ST_FILL: begin
            // read issued for tap_ff, data lands next cycle
            first_ff <= 1'b0;
            if (!first_ff) begin
               for (int k = TAPS; k >= 1; k--) begin
                  tap_re_ff[k] <= tap_re_ff[k-1];
                  tap_im_ff[k] <= tap_im_ff[k-1];
               end
               tap_re_ff[0] <= srd_re_ff;
               tap_im_ff[0] <= srd_im_ff;
            end
            tap_ff <= tap_ff + TI_W'(1);
            if (!first_ff && tap_ff == TI_W'(TAPS + 1)) begin
               rpos_ff <= 12'(TAPS + 1);
               acc_ff  <= 13'd1024;
               cnt_ff  <= '0;
            end
         end
         ST_SHIFT: begin
            // alternate: issue read, then shift it in
            if (first_ff) begin
               if (acc_ff >= 13'd2048) first_ff <= 1'b0;
            end else begin
               for (int k = TAPS; k >= 1; k--) begin
                  tap_re_ff[k] <= tap_re_ff[k-1];
                  tap_im_ff[k] <= tap_im_ff[k-1];
               end
               tap_re_ff[0] <= srd_re_ff;
               tap_im_ff[0] <= srd_im_ff;
               acc_ff   <= acc_ff - 13'd2048;
               rpos_ff  <= rpos_ff + 12'd1;
               first_ff <= 1'b1;
            end
         end
         ST_CINT:
            cint_ff <= (COEF_BITS+2)'(pfr_pkg::round_shift(
                        (64'(c1_ff) <<< 11) + 64'(prod), 11));
         ST_MRE:
            are_ff <= are_ff + 48'(pfr_pkg::round_shift(64'(prod), COEF_BITS - 1));
         ST_MIM: begin
            aim_ff <= aim_ff + 48'(pfr_pkg::round_shift(64'(prod), COEF_BITS - 1));
            tap_ff <= tap_ff + TI_W'(1);
            first_ff <= 1'b1;
         end
         ST_CORR: begin
            first_ff <= 1'b0;
            if (first_ff)
               are_ff <= are_ff + 48'(pfr_pkg::round_shift(pfr_pkg::round_shift(
                         64'(prod), 11) <<< 2, COEF_BITS - 1));
            else
               aim_ff <= aim_ff + 48'(pfr_pkg::round_shift(pfr_pkg::round_shift(
                         64'(prod), 11) <<< 2, COEF_BITS - 1));
         end
         ST_OUT: begin
            if (out_go) begin
               rdata_ff  <= {5'd0, cnt_ff[10:0], pfr_pkg::sat20(aim_ff),
                             pfr_pkg::sat20(are_ff)};
               rlast_ff  <= (cnt_ff == len - 12'd1);
               acc_ff    <= acc_ff + 13'(({12'd0, blen_ff} << 11) >> ldn);
               cnt_ff    <= cnt_ff + 12'd1;
            end
         end
         default: ;
      endcase
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         acc_ff    <= 13'd1024;
         rpos_ff   <= '0;
         cnt_ff    <= '0;
         for (int k = 0; k <= TAPS; k++) begin
            tap_re_ff[k] <= '0;
            tap_im_ff[k] <= '0;
         end
      end
   end

   `PFR_ASSERT_NEXT(a_load_next, req_tvalid && req_tready && req_tuser == pfr_pkg::REQ_LOAD_SAMPLE, state_ff == ST_LOAD)
   `PFR_ASSERT_NEXT(a_out_gives_rsp, state_ff == ST_OUT, rvalid_ff)
   `PFR_ASSERT_NEXT(a_rsp_hold, rvalid_ff && !rsp_tready, rvalid_ff && $stable(rdata_ff))

endmodule
